### sv/tank_level_alarm_controller_assert.svh
// assertion macros for the tank level alarm controller
// used by the controller and datapath modules, expects clk_i and rst_ni in scope
`ifndef TANK_LEVEL_ALARM_CONTROLLER_ASSERT_SVH
`define TANK_LEVEL_ALARM_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define TLAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tlac assertion failed");
// condition that must never hold
`define TLAC_ASSERT_NEVER(lbl, cond) `TLAC_ASSERT(lbl, !(cond))
`else
`define TLAC_ASSERT(lbl, prop)
`define TLAC_ASSERT_NEVER(lbl, cond)
`endif
`endif

### sv/tlac_pkg.sv
// shared types, codes and reset values for the tank level alarm controller
// no dependencies
`default_nettype none
package tlac_pkg;

  // field widths
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned MARGIN_W = 10;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned RETRY_W  = 3;
  localparam int unsigned WELL_W   = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned SMS_W    = 2;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam int unsigned NUM_WELLS_DEF = 16;

  // configuration reset values
  localparam logic [LEVEL_W-1:0]  LOW_THR_RST   = 16'd200;
  localparam logic [LEVEL_W-1:0]  HIGH_THR_RST  = 16'd1000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST    = 10'd50;
  localparam logic [TICK_W-1:0]   TIMEOUT_RST   = 8'd180;
  localparam logic [TICK_W-1:0]   PERIOD_RST    = 8'd60;
  localparam logic [RETRY_W-1:0]  RETRY_LIM_RST = 3'd3;

  // request and command codes
  localparam logic             REQ_TICK    = 1'b0;
  localparam logic             REQ_RESP    = 1'b1;
  localparam logic [SMS_W-1:0] SMS_DISABLE = 2'd0;
  localparam logic [SMS_W-1:0] SMS_ENABLE  = 2'd1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    LINK_DOWN = 2'd0,
    LINK_UP   = 2'd1,
    LINK_NONE = 2'd2
  } link_e;

  typedef enum logic [2:0] {
    REG_LOW_THR   = 3'd0,
    REG_HIGH_THR  = 3'd1,
    REG_MARGIN    = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_PERIOD    = 3'd4,
    REG_RETRY_LIM = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  low_thr;
    logic [LEVEL_W-1:0]  high_thr;
    logic [MARGIN_W-1:0] margin;
    logic [TICK_W-1:0]   timeout;
    logic [TICK_W-1:0]   period;
    logic [RETRY_W-1:0]  retry_lim;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic resp_in;
    logic presc_zero;
    logic well_emit;
    logic scan_done;
    logic out_free;
    logic any_emitted;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/tlac_if.sv
// valid/ready channel interfaces for request and result items
// depends on tlac_pkg
`default_nettype none
interface tlac_in_if;
  import tlac_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LEVEL_W-1:0] level_sample;
  logic [SMS_W-1:0]   sms_command;
  logic [MASK_W-1:0]  link_mask;

  modport source (output valid, req_type, level_sample, sms_command, link_mask,
                  input ready);
  modport sink (input valid, req_type, level_sample, sms_command, link_mask,
                output ready);
endinterface

interface tlac_out_if;
  import tlac_pkg::*;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [WELL_W-1:0] well_index;
  logic              pump_on;
  logic [1:0]        tank_mode;
  logic              last;

  modport source (output valid, send_valid, well_index, pump_on, tank_mode, last,
                  input ready);
  modport sink (input valid, send_valid, well_index, pump_on, tank_mode, last,
                output ready);
endinterface
`default_nettype wire

### sv/tlac_regs.sv
// apb configuration registers of the tank level alarm controller
// depends on tlac_pkg
`default_nettype none
module tlac_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlac_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlac_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlac_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output tlac_pkg::cfg_t                 cfg_o
);
  import tlac_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr   <= LOW_THR_RST;
      cfg_q.high_thr  <= HIGH_THR_RST;
      cfg_q.margin    <= MARGIN_RST;
      cfg_q.timeout   <= TIMEOUT_RST;
      cfg_q.period    <= PERIOD_RST;
      cfg_q.retry_lim <= RETRY_LIM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LOW_THR:   cfg_q.low_thr   <= pwdata[LEVEL_W-1:0];
        REG_HIGH_THR:  cfg_q.high_thr  <= pwdata[LEVEL_W-1:0];
        REG_MARGIN:    cfg_q.margin    <= pwdata[MARGIN_W-1:0];
        REG_TIMEOUT:   cfg_q.timeout   <= pwdata[TICK_W-1:0];
        REG_PERIOD:    cfg_q.period    <= pwdata[TICK_W-1:0];
        REG_RETRY_LIM: cfg_q.retry_lim <= pwdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_LOW_THR:   prdata = PDATA_W'(cfg_q.low_thr);
      REG_HIGH_THR:  prdata = PDATA_W'(cfg_q.high_thr);
      REG_MARGIN:    prdata = PDATA_W'(cfg_q.margin);
      REG_TIMEOUT:   prdata = PDATA_W'(cfg_q.timeout);
      REG_PERIOD:    prdata = PDATA_W'(cfg_q.period);
      REG_RETRY_LIM: prdata = PDATA_W'(cfg_q.retry_lim);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/tlac_ctrl.sv
// sequencing state machine: accept, well scan, mode update, status item
// depends on tlac_pkg and the assertion macro header
`default_nettype none
`include "tank_level_alarm_controller_assert.svh"
module tlac_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tlac_pkg::dp_stat_t    stat_i,
  output tlac_pkg::ctrl_cmd_t   cmd_o
);
  import tlac_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_STATUS
  } state_e;

  state_e state_q;

  // commands to the datapath
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == ST_SCAN) && (!stat_i.well_emit || stat_i.out_free);
    cmd_o.finish = (state_q == ST_FINISH);
    cmd_o.status = (state_q == ST_STATUS) && stat_i.out_free;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (stat_i.resp_in)         state_q <= ST_STATUS;
            else if (stat_i.presc_zero) state_q <= ST_SCAN;
            else                        state_q <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (cmd_o.step && stat_i.scan_done) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          state_q <= stat_i.any_emitted ? ST_IDLE : ST_STATUS;
        end
        ST_STATUS: begin
          if (stat_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  `TLAC_ASSERT(a_one_item_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `TLAC_ASSERT(a_finish_exit, (state_q == ST_FINISH) |=> (state_q == ST_IDLE || state_q == ST_STATUS))
  `TLAC_ASSERT_NEVER(a_step_vs_status, cmd_o.step && cmd_o.status)

endmodule
`default_nettype wire

### sv/tlac_dp.sv
// datapath: watchdog, prescaler, mode, per-well link and retry state, result register
// depends on tlac_pkg and the assertion macro header
`default_nettype none
`include "tank_level_alarm_controller_assert.svh"
module tlac_dp #(
  parameter int unsigned NUM_WELLS = tlac_pkg::NUM_WELLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlac_pkg::cfg_t                 cfg_i,
  input  tlac_pkg::ctrl_cmd_t            cmd_i,
  output tlac_pkg::dp_stat_t             stat_o,
  input  logic                           req_type_i,
  input  logic [tlac_pkg::LEVEL_W-1:0]   level_sample_i,
  input  logic [tlac_pkg::SMS_W-1:0]     sms_command_i,
  input  logic [tlac_pkg::MASK_W-1:0]    link_mask_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           send_valid_o,
  output logic [tlac_pkg::WELL_W-1:0]    well_index_o,
  output logic                           pump_on_o,
  output logic [1:0]                     tank_mode_o,
  output logic                           last_o
);
  import tlac_pkg::*;

  localparam int unsigned IdxW = (NUM_WELLS > 1) ? $clog2(NUM_WELLS) : 1;

  mode_e              mode_q;
  mode_e              new_mode_q;
  mode_e              next_mode;
  logic [TICK_W-1:0]  timer_q;
  logic [TICK_W-1:0]  presc_q;
  logic               enabled_q;
  link_e              link_q [NUM_WELLS];
  logic [RETRY_W-1:0] retries_q [NUM_WELLS];
  logic [IdxW-1:0]    idx_q;
  logic               emitted_q;

  logic               out_valid_q;
  logic               out_send_q;
  logic [WELL_W-1:0]  out_idx_q;
  logic               out_pump_q;
  mode_e              out_mode_q;
  logic               out_last_q;

  logic [LEVEL_W:0]   hi_lim;
  logic [LEVEL_W:0]   lvl_plus;
  logic               is_high;
  logic               is_low;
  logic               is_norm;
  logic               well_emit;
  logic               higher_nz;
  logic               out_free;
  logic               load_cmd;
  logic               arm;

  // level tests, low side compared as level + margin < low to avoid wrap
  always_comb begin
    hi_lim   = {1'b0, cfg_i.high_thr} + (LEVEL_W+1)'(cfg_i.margin);
    lvl_plus = {1'b0, level_sample_i} + (LEVEL_W+1)'(cfg_i.margin);
    is_high  = {1'b0, level_sample_i} > hi_lim;
    is_low   = lvl_plus < {1'b0, cfg_i.low_thr};
    is_norm  = !is_high && !is_low;
  end

  // mode transition
  always_comb begin
    next_mode = mode_q;
    case (mode_q)
      MODE_LOW: begin
        if (is_high)      next_mode = MODE_HIGH;
        else if (is_norm) next_mode = MODE_NORMAL;
      end
      MODE_HIGH: begin
        if (is_norm)     next_mode = MODE_NORMAL;
        else if (is_low) next_mode = MODE_LOW;
      end
      default: begin
        if (is_high)     next_mode = MODE_HIGH;
        else if (is_low) next_mode = MODE_LOW;
      end
    endcase
  end

  // scan of the current well and whether a later well still has retries
  always_comb begin
    higher_nz = 1'b0;
    for (int j = 0; j < NUM_WELLS; j++) begin
      if (j > int'(idx_q) && retries_q[j] != '0) higher_nz = 1'b1;
    end
  end

  assign well_emit = (retries_q[idx_q] != '0) && (mode_q != MODE_NORMAL);
  assign out_free  = !out_valid_q || out_ready_i;
  assign load_cmd  = cmd_i.step && well_emit;
  assign arm       = (new_mode_q != mode_q) && (new_mode_q != MODE_NORMAL) && enabled_q;

  // status to the controller
  always_comb begin
    stat_o.resp_in     = (req_type_i == REQ_RESP);
    stat_o.presc_zero  = (presc_q == '0);
    stat_o.well_emit   = well_emit;
    stat_o.scan_done   = (idx_q == IdxW'(NUM_WELLS - 1));
    stat_o.out_free    = out_free;
    stat_o.any_emitted = emitted_q;
  end

  // tank, watchdog and well state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      new_mode_q <= MODE_NORMAL;
      timer_q    <= TIMEOUT_RST;
      presc_q    <= PERIOD_RST;
      enabled_q  <= 1'b1;
      idx_q      <= '0;
      emitted_q  <= 1'b0;
      for (int i = 0; i < NUM_WELLS; i++) begin
        link_q[i]    <= LINK_NONE;
        retries_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      idx_q     <= '0;
      emitted_q <= 1'b0;
      if (req_type_i == REQ_RESP) begin
        // server response
        new_mode_q <= mode_q;
        timer_q    <= cfg_i.timeout;
        if (sms_command_i == SMS_DISABLE)     enabled_q <= 1'b0;
        else if (sms_command_i == SMS_ENABLE) enabled_q <= 1'b1;
        for (int i = 0; i < NUM_WELLS; i++) begin
          link_q[i] <= link_mask_i[i] ? LINK_UP : LINK_DOWN;
        end
      end else begin
        // tick: next mode, watchdog and prescaler
        new_mode_q <= next_mode;
        if (timer_q != '0) begin
          timer_q <= timer_q - 1'b1;
        end else begin
          for (int i = 0; i < NUM_WELLS; i++) link_q[i] <= LINK_DOWN;
        end
        if (presc_q != '0) presc_q <= presc_q - 1'b1;
        else               presc_q <= cfg_i.period;
      end
    end else if (cmd_i.step) begin
      // one well per cycle of the send pass, unless a stalled output holds a well that emits
      if (retries_q[idx_q] != '0) retries_q[idx_q] <= retries_q[idx_q] - 1'b1;
      if (well_emit) emitted_q <= 1'b1;
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.finish) begin
      // commit mode and arm down wells on entry to low or high when sends are enabled
      mode_q <= new_mode_q;
      if (arm) begin
        for (int i = 0; i < NUM_WELLS; i++) begin
          if (link_q[i] == LINK_DOWN) retries_q[i] <= cfg_i.retry_lim;
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_cmd || cmd_i.status) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      out_send_q <= 1'b1;
      out_idx_q  <= WELL_W'(idx_q);
      out_pump_q <= (mode_q == MODE_LOW);
      out_mode_q <= new_mode_q;
      out_last_q <= !higher_nz;
    end else if (cmd_i.status) begin
      out_send_q <= 1'b0;
      out_idx_q  <= '0;
      out_pump_q <= 1'b0;
      out_mode_q <= new_mode_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_valid_o = out_send_q;
  assign well_index_o = out_idx_q;
  assign pump_on_o    = out_pump_q;
  assign tank_mode_o  = out_mode_q;
  assign last_o       = out_last_q;

  // checks
  `TLAC_ASSERT(a_cmd_well_in_range, (out_valid_q && out_send_q) |-> (int'(out_idx_q) < NUM_WELLS))
  `TLAC_ASSERT(a_status_is_last, (out_valid_q && !out_send_q) |-> (out_last_q && !out_pump_q && out_idx_q == '0))
  `TLAC_ASSERT_NEVER(a_no_overwrite, out_valid_q && !out_ready_i && (load_cmd || cmd_i.status))

endmodule
`default_nettype wire

### sv/tank_level_alarm_controller.sv
// top level of the tank level alarm controller
// depends on tlac_pkg, tlac_if, tlac_regs, tlac_ctrl and tlac_dp
//
//  channel  dir  handshake          carries
//  in_i     in   valid/ready        req_type, level_sample, sms_command, link_mask
//  out_o    out  valid/ready        send_valid, well_index, pump_on, tank_mode, last
//  apb      in   psel/penable/pready configuration writes and reads
//
// a server response item goes to its status item, a tick with no send pass goes
// through finish to the status item, a tick with a send pass through the scan, finish
// and the status item when no command comes out; the scan visits one well per cycle
// reset leaves the tank normal, all links unknown and no retries armed
// a stalled output holds the scan on the next well that emits a command
`default_nettype none
module tank_level_alarm_controller #(
  parameter int unsigned NUM_WELLS = tlac_pkg::NUM_WELLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tlac_in_if.sink                       in_i,
  tlac_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlac_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlac_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlac_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tlac_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_i.ready = in_ready;

  // configuration registers
  tlac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  tlac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // state and result register
  tlac_dp #(
    .NUM_WELLS (NUM_WELLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (in_i.req_type),
    .level_sample_i (in_i.level_sample),
    .sms_command_i  (in_i.sms_command),
    .link_mask_i    (in_i.link_mask),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .send_valid_o   (out_o.send_valid),
    .well_index_o   (out_o.well_index),
    .pump_on_o      (out_o.pump_on),
    .tank_mode_o    (out_o.tank_mode),
    .last_o         (out_o.last)
  );

endmodule
`default_nettype wire

### verif/tb_tank_level_alarm_controller.sv
// testbench for the tank level alarm controller: directed and random request items,
// per-field checking of every result item against a local predictor
// depends on tlac_pkg, tlac_if and the tank_level_alarm_controller rtl
module tb_tank_level_alarm_controller;
  import tlac_pkg::*;

  localparam int unsigned WELLS           = NUM_WELLS_DEF;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  typedef struct {
    logic               req_type;
    logic [LEVEL_W-1:0] level;
    logic [SMS_W-1:0]   sms;
    logic [MASK_W-1:0]  mask;
  } req_item_t;

  typedef struct {
    logic              send_valid;
    logic [WELL_W-1:0] well;
    logic              pump_on;
    logic [1:0]        mode;
    logic              last;
  } pump_item_t;

  // predictor of the supervisor plus the queue of pump items it still expects
  class tank_scoreboard;
    cfg_t              cfg;
    mode_e             mode;
    logic [TICK_W-1:0] watchdog;
    logic [TICK_W-1:0] prescaler;
    logic              sends_en;
    link_e             links [WELLS];
    logic [RETRY_W-1:0] retries [WELLS];
    pump_item_t        pending [$];
    int                errors;
    int                n_ticks;
    int                n_resps;
    int                n_results;
    int                n_cmds;

    function new();
      cfg = '{low_thr: LOW_THR_RST, high_thr: HIGH_THR_RST, margin: MARGIN_RST,
              timeout: TIMEOUT_RST, period: PERIOD_RST, retry_lim: RETRY_LIM_RST};
      mode      = MODE_NORMAL;
      watchdog  = TIMEOUT_RST;
      prescaler = PERIOD_RST;
      sends_en  = 1'b1;
      foreach (links[i]) begin
        links[i]   = LINK_NONE;
        retries[i] = '0;
      end
      errors    = 0;
      n_ticks   = 0;
      n_resps   = 0;
      n_results = 0;
      n_cmds    = 0;
    endfunction

    function void apply_cfg(reg_idx_e idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_LOW_THR:   cfg.low_thr   = val[LEVEL_W-1:0];
        REG_HIGH_THR:  cfg.high_thr  = val[LEVEL_W-1:0];
        REG_MARGIN:    cfg.margin    = val[MARGIN_W-1:0];
        REG_TIMEOUT:   cfg.timeout   = val[TICK_W-1:0];
        REG_PERIOD:    cfg.period    = val[TICK_W-1:0];
        REG_RETRY_LIM: cfg.retry_lim = val[RETRY_W-1:0];
        default: ;
      endcase
    endfunction

    // work out the pump items one accepted request causes
    function void note_request(req_item_t it);
      mode_e      old_mode;
      mode_e      new_mode;
      pump_item_t r;
      pump_item_t step_out [$];
      int         lvl;
      int         hi_lim;
      int         lo_lim;
      logic       is_hi;
      logic       is_lo;
      if (it.req_type == REQ_RESP) begin
        // server response reloads the watchdog and gives every link state
        n_resps++;
        watchdog = cfg.timeout;
        if (it.sms == SMS_DISABLE) sends_en = 1'b0;
        else if (it.sms == SMS_ENABLE) sends_en = 1'b1;
        foreach (links[i]) links[i] = it.mask[i] ? LINK_UP : LINK_DOWN;
      end else begin
        n_ticks++;
        old_mode = mode;
        // watchdog run out marks every link down
        if (watchdog != 0) watchdog--;
        else foreach (links[i]) links[i] = LINK_DOWN;
        // send pass on prescaler expiry, commands follow the mode held before the tick
        if (prescaler != 0) begin
          prescaler--;
        end else begin
          prescaler = cfg.period;
          for (int i = 0; i < WELLS; i++) begin
            if (retries[i] != 0) begin
              retries[i]--;
              if (old_mode != MODE_NORMAL) begin
                r.send_valid = 1'b1;
                r.well       = WELL_W'(i);
                r.pump_on    = (old_mode == MODE_LOW);
                step_out.push_back(r);
              end
            end
          end
        end
        // level tests with the margin, low bound may go negative
        lvl    = int'(it.level);
        hi_lim = int'(cfg.high_thr) + int'(cfg.margin);
        lo_lim = int'(cfg.low_thr) - int'(cfg.margin);
        is_hi  = lvl > hi_lim;
        is_lo  = lvl < lo_lim;
        new_mode = old_mode;
        case (old_mode)
          MODE_LOW: begin
            if (is_hi) new_mode = MODE_HIGH;
            else if (!is_lo) new_mode = MODE_NORMAL;
          end
          MODE_HIGH: begin
            if (!is_hi && !is_lo) new_mode = MODE_NORMAL;
            else if (is_lo) new_mode = MODE_LOW;
          end
          default: begin
            if (is_hi) new_mode = MODE_HIGH;
            else if (is_lo) new_mode = MODE_LOW;
          end
        endcase
        mode = new_mode;
        // entry into an alarm mode arms the down wells when sends are enabled
        if (new_mode != old_mode && new_mode != MODE_NORMAL && sends_en) begin
          foreach (links[i]) if (links[i] == LINK_DOWN) retries[i] = cfg.retry_lim;
        end
      end
      // status item when no command comes out
      if (step_out.size() == 0) begin
        r.send_valid = 1'b0;
        r.well       = '0;
        r.pump_on    = 1'b0;
        step_out.push_back(r);
      end
      foreach (step_out[i]) begin
        step_out[i].mode = mode;
        step_out[i].last = (i == step_out.size() - 1);
        pending.push_back(step_out[i]);
      end
    endfunction

    function void cmp_field(string name, logic [3:0] want, logic [3:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(pump_item_t got);
      pump_item_t want;
      n_results++;
      if (got.send_valid === 1'b1) n_cmds++;
      if (pending.size() == 0) begin
        $error("pump item with nothing expected: send_valid %0b well %0d",
               got.send_valid, got.well);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("send_valid", want.send_valid, got.send_valid);
      cmp_field("well_index", want.well, got.well);
      cmp_field("pump_on", want.pump_on, got.pump_on);
      cmp_field("tank_mode", want.mode, got.mode);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tlac_in_if  req_if ();
  tlac_out_if res_if ();

  tank_level_alarm_controller u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tank_scoreboard sb;
  int             burst_left;
  int             n_phases;
  logic [15:0]    stall_pattern;
  int             stall_pos;
  int             pattern_age;

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver stalls on a changing bit pattern, sometimes always ready
  always @(negedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pattern = 16'hFFFF;
        1: stall_pattern = 16'($urandom) | 16'h0001;
        2: stall_pattern = (16'h0001 << $urandom_range(15, 0)) | 16'h0001;
        default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
      endcase
      pattern_age = $urandom_range(120, 20);
    end
    pattern_age--;
    res_if.ready <= stall_pattern[stall_pos];
    stall_pos = (stall_pos + 1) % 16;
  end

  // note accepted requests and check accepted results
  always @(posedge clk_i) begin
    req_item_t  it;
    pump_item_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        it.req_type = req_if.req_type;
        it.level    = req_if.level_sample;
        it.sms      = req_if.sms_command;
        it.mask     = req_if.link_mask;
        sb.note_request(it);
      end
      if (res_if.valid && res_if.ready) begin
        got.send_valid = res_if.send_valid;
        got.well       = res_if.well_index;
        got.pump_on    = res_if.pump_on;
        got.mode       = res_if.tank_mode;
        got.last       = res_if.last;
        sb.check_result(got);
      end
    end
  end

  function automatic req_item_t mk_tick(logic [LEVEL_W-1:0] level);
    req_item_t it;
    it.req_type = REQ_TICK;
    it.level    = level;
    it.sms      = SMS_W'($urandom);
    it.mask     = MASK_W'($urandom);
    return it;
  endfunction

  function automatic req_item_t mk_resp(logic [SMS_W-1:0] sms, logic [MASK_W-1:0] mask);
    req_item_t it;
    it.req_type = REQ_RESP;
    it.level    = LEVEL_W'($urandom);
    it.sms      = sms;
    it.mask     = mask;
    return it;
  endfunction

  // level aimed at the low, high or normal band of the current thresholds
  function automatic logic [LEVEL_W-1:0] pick_level();
    int lo_lim;
    int hi_lim;
    int kind;
    lo_lim = int'(sb.cfg.low_thr) - int'(sb.cfg.margin);
    hi_lim = int'(sb.cfg.high_thr) + int'(sb.cfg.margin);
    kind   = $urandom_range(99, 0);
    if (kind < 30 && lo_lim > 0) return LEVEL_W'($urandom_range(lo_lim - 1, 0));
    if (kind < 60 && hi_lim < 65535) return LEVEL_W'($urandom_range(65535, hi_lim + 1));
    if (kind < 85 && lo_lim <= hi_lim)
      return LEVEL_W'($urandom_range(hi_lim > 65535 ? 65535 : hi_lim, lo_lim < 0 ? 0 : lo_lim));
    if (kind < 90) return '0;
    if (kind < 95) return '1;
    return LEVEL_W'($urandom);
  endfunction

  function automatic req_item_t random_item();
    logic [MASK_W-1:0] mask;
    int                kind;
    if ($urandom_range(99, 0) >= 15) return mk_tick(pick_level());
    kind = $urandom_range(9, 0);
    if (kind < 2) mask = '0;
    else if (kind < 3) mask = '1;
    else if (kind < 5) mask = MASK_W'($urandom & $urandom);
    else mask = MASK_W'($urandom);
    return mk_resp(SMS_W'($urandom_range(3, 0)), mask);
  endfunction

  // fixed extremes first, then random settings, the last with the longest send period
  function automatic cfg_t phase_cfg(int p);
    cfg_t c;
    int   tmp;
    case (p)
      0: c = '{low_thr: 300, high_thr: 700, margin: 1023, timeout: 255, period: 1, retry_lim: 7};
      1: c = '{low_thr: 65535, high_thr: 65535, margin: 0, timeout: 1, period: 0, retry_lim: 1};
      2: c = '{low_thr: 0, high_thr: 0, margin: 0, timeout: 3, period: 2, retry_lim: 0};
      default: begin
        c.low_thr = LEVEL_W'($urandom_range(60000, 0));
        if ($urandom_range(4, 0) == 0) begin
          c.high_thr = LEVEL_W'($urandom_range(c.low_thr, 0));
        end else begin
          tmp = int'(c.low_thr) + $urandom_range(20000, 0);
          c.high_thr = LEVEL_W'(tmp > 65535 ? 65535 : tmp);
        end
        c.margin    = MARGIN_W'($urandom_range(300, 0));
        c.timeout   = ($urandom_range(9, 0) == 0) ? TICK_W'($urandom_range(255, 0))
                                                  : TICK_W'($urandom_range(12, 1));
        c.period    = TICK_W'($urandom_range(3, 0));
        c.retry_lim = RETRY_W'($urandom_range(7, 0));
        if (p == PHASES - 1) c.period = 8'd255;
      end
    endcase
    return c;
  endfunction

  // apb write, then read back the same register
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.apply_cfg(idx, val);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $error("register %s readback mismatch: expected %0d, got %0d", idx.name(), val, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(REG_LOW_THR, PDATA_W'(c.low_thr));
    write_reg(REG_HIGH_THR, PDATA_W'(c.high_thr));
    write_reg(REG_MARGIN, PDATA_W'(c.margin));
    write_reg(REG_TIMEOUT, PDATA_W'(c.timeout));
    write_reg(REG_PERIOD, PDATA_W'(c.period));
    write_reg(REG_RETRY_LIM, PDATA_W'(c.retry_lim));
    n_phases++;
  endtask

  // sender works in bursts with random gaps in between
  task automatic send_req(input req_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(12, 1);
    end
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= it.req_type;
    req_if.level_sample <= it.level;
    req_if.sms_command  <= it.sms;
    req_if.link_mask    <= it.mask;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    burst_left--;
  endtask

  // stop sending and let every expected item come out, then let the scan settle
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (WELLS + 8) @(posedge clk_i);
  endtask

  initial begin
    sb            = new();
    burst_left    = 0;
    n_phases      = 0;
    stall_pattern = 16'hFFFF;
    stall_pos     = 0;
    pattern_age   = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_TICK;
    req_if.level_sample = '0;
    req_if.sms_command  = SMS_DISABLE;
    req_if.link_mask    = '0;
    res_if.ready        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: band edges, extremes and all send-enable codes
    send_req(mk_resp(SMS_ENABLE, 16'h0000));
    send_req(mk_tick(16'd0));
    send_req(mk_tick(16'hFFFF));
    send_req(mk_tick(16'd500));
    send_req(mk_tick(16'd149));
    send_req(mk_tick(16'd150));
    send_req(mk_tick(16'd1050));
    send_req(mk_tick(16'd1051));
    // disabled sends arm nothing on alarm entry
    send_req(mk_resp(SMS_DISABLE, 16'hA5A5));
    send_req(mk_tick(16'd0));
    send_req(mk_resp(2'd3, 16'hFFFF));
    send_req(mk_resp(2'd2, 16'h5A5A));
    send_req(mk_tick(16'hFFFF));
    drain_results();

    // crossed thresholds with zero watchdog and zero send period
    program_cfg('{low_thr: 65535, high_thr: 0, margin: 0, timeout: 0, period: 0,
                  retry_lim: 7});
    send_req(mk_resp(SMS_ENABLE, 16'h0000));
    send_req(mk_tick(16'd100));
    send_req(mk_tick(16'd100));
    send_req(mk_tick(16'd0));
    send_req(mk_tick(16'hFFFF));
    drain_results();

    // random items under a run of settings
    for (int p = 0; p < PHASES; p++) begin
      program_cfg(phase_cfg(p));
      repeat (ITEMS_PER_PHASE) send_req(random_item());
      drain_results();
    end

    $display("%0d request items (%0d ticks, %0d server responses) over %0d register settings",
             sb.n_ticks + sb.n_resps, sb.n_ticks, sb.n_resps, n_phases + 1);
    $display("%0d result items checked, %0d of them pump commands", sb.n_results, sb.n_cmds);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### tank_level_alarm_controller.f
+incdir+sv
sv/tlac_pkg.sv
sv/tlac_if.sv
sv/tlac_regs.sv
sv/tlac_ctrl.sv
sv/tlac_dp.sv
sv/tank_level_alarm_controller.sv
verif/tb_tank_level_alarm_controller.sv
